>>> src/h264sps_pkg.sv
// Shared types and constants for the H.264 SPS frame size parser.
// Used by the byte queue, the bit parser and the size stage; no dependencies.
package h264sps_pkg;

	typedef enum logic [4:0] {
		F_IDLE       = 5'd0,
		F_CONSTR     = 5'd1,
		F_LEVEL      = 5'd2,
		F_SPS_ID     = 5'd3,
		F_CHROMA     = 5'd4,
		F_RESID      = 5'd5,
		F_DEPTH_L    = 5'd6,
		F_DEPTH_C    = 5'd7,
		F_BYPASS     = 5'd8,
		F_SCALE_FLAG = 5'd9,
		F_SCALE_LIST = 5'd10,
		F_FRAME_NUM  = 5'd11,
		F_POC_TYPE   = 5'd12,
		F_POC_LSB    = 5'd13,
		F_DELTA_ZERO = 5'd14,
		F_OFF_NONREF = 5'd15,
		F_OFF_TB     = 5'd16,
		F_NUM_CYCLE  = 5'd17,
		F_OFF_REF    = 5'd18,
		F_NUM_REF    = 5'd19,
		F_GAPS       = 5'd20,
		F_WIDTH      = 5'd21,
		F_HEIGHT     = 5'd22,
		F_FMO        = 5'd23,
		F_MBAFF      = 5'd24,
		F_DIRECT     = 5'd25,
		F_CROP_FLAG  = 5'd26,
		F_CROP0      = 5'd27,
		F_CROP1      = 5'd28,
		F_CROP2      = 5'd29,
		F_CROP3      = 5'd30,
		F_DONE       = 5'd31
	} field_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SCALING  = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_CROP     = 3'd3,
		ST_OVERLONG = 3'd4
	} status_t;

	localparam logic [7:0] PROF_HIGH     = 8'd100;
	localparam logic [7:0] PROF_HIGH10   = 8'd110;
	localparam logic [7:0] PROF_HIGH422  = 8'd122;
	localparam logic [7:0] PROF_HIGH444  = 8'd244;
	localparam logic [7:0] PROF_CAVLC444 = 8'd44;
	localparam logic [7:0] PROF_SCALAB   = 8'd83;
	localparam logic [7:0] PROF_MVIEW    = 8'd86;

	localparam logic [31:0] SCALE_LISTS_STD = 32'd8;
	localparam logic [31:0] SCALE_LISTS_444 = 32'd12;
	localparam logic [5:0]  MAX_PREFIX      = 6'd32;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		field_t      field;
		logic [5:0]  lz;
		logic [31:0] accum;
		logic [5:0]  left;
		logic [7:0]  profile;
		logic [1:0]  chroma;
		logic [31:0] rep;
		logic [15:0] wib;
		logic [15:0] hiu;
		logic        fo;
		logic [15:0] crop0;
		logic [15:0] crop1;
		logic [15:0] crop2;
		logic [15:0] crop3;
		logic        sent;
	} parse_st_t;

	// Finish request handed from the parser to the size stage
	typedef struct packed {
		logic        fin;
		status_t     status;
		logic [15:0] wib;
		logic [15:0] hiu;
		logic        fo;
		logic [1:0]  chroma;
		logic [15:0] crop0;
		logic [15:0] crop1;
		logic [15:0] crop2;
		logic [15:0] crop3;
	} size_req_t;

	function automatic logic high_profile(logic [7:0] p);
		return p == PROF_HIGH || p == PROF_HIGH10 || p == PROF_HIGH422 ||
			p == PROF_HIGH444 || p == PROF_CAVLC444 || p == PROF_SCALAB ||
			p == PROF_MVIEW;
	endfunction

	function automatic logic [15:0] sat16(logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

>>> src/h264sps_queue.sv
// Front of the SPS parser: a two-entry byte queue that takes input requests.
// Depends on h264sps_pkg for the byte item type.
module h264sps_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  h264sps_pkg::byte_item_t in_item,
	output logic                    q_valid,
	output h264sps_pkg::byte_item_t q_item,
	input  logic                    q_pop
);
	import h264sps_pkg::*;

	byte_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_item;
	end

endmodule

>>> src/h264sps_parse.sv
// Back of the SPS parser: walks the eight bits of one byte per cycle through the syntax
// fields, unless a finish request waits, and registers a finish request. Depends on h264sps_pkg.
module h264sps_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  h264sps_pkg::byte_item_t q_item,
	output logic                    q_pop,
	output logic                    req_valid,
	output h264sps_pkg::size_req_t  req,
	input  logic                    req_take
);
	import h264sps_pkg::*;

	typedef struct packed {
		parse_st_t st;
		logic      done;
		logic      fin;
		status_t   status;
	} step_t;

	// idle field, everything cleared, sent flag (last member) set
	localparam parse_st_t ST_RESET = parse_st_t'({{($bits(parse_st_t) - 1){1'b0}}, 1'b1});

	function automatic step_t bit_step(parse_st_t s, logic b);
		step_t       r;
		logic        ready;
		logic [31:0] v;
		r        = '0;
		r.st     = s;
		r.status = ST_OK;
		ready    = 1'b0;
		v        = '0;
		unique case (s.field)
			F_RESID:      r.st.field = F_DEPTH_L;
			F_BYPASS:     r.st.field = F_SCALE_FLAG;
			F_SCALE_FLAG: begin
				if (b) begin
					r.st.rep   = (s.chroma == 2'd3) ? SCALE_LISTS_444 : SCALE_LISTS_STD;
					r.st.field = F_SCALE_LIST;
				end else begin
					r.st.field = F_FRAME_NUM;
				end
			end
			F_SCALE_LIST: begin
				if (b) begin
					r.done   = 1'b1;
					r.status = ST_SCALING;
				end else begin
					r.st.rep = s.rep - 32'd1;
					if (s.rep == 32'd1)
						r.st.field = F_FRAME_NUM;
				end
			end
			F_DELTA_ZERO: r.st.field = F_OFF_NONREF;
			F_GAPS:       r.st.field = F_WIDTH;
			F_FMO: begin
				r.st.fo    = b;
				r.st.field = b ? F_DIRECT : F_MBAFF;
			end
			F_MBAFF:      r.st.field = F_DIRECT;
			F_DIRECT:     r.st.field = F_CROP_FLAG;
			F_CROP_FLAG: begin
				if (b) begin
					r.st.field = F_CROP0;
				end else begin
					r.done = 1'b1;
					r.fin  = 1'b1;
				end
			end
			default: begin
				// Exp-Golomb: count the zero prefix, then collect the suffix
				if (s.left == 6'd0) begin
					if (!b) begin
						r.st.lz = s.lz + 6'd1;
						if (r.st.lz >= MAX_PREFIX) begin
							r.st.lz  = 6'd0;
							r.done   = 1'b1;
							r.status = ST_OVERLONG;
						end
					end else if (s.lz == 6'd0) begin
						ready = 1'b1;
					end else begin
						r.st.left  = s.lz;
						r.st.accum = '0;
					end
				end else begin
					r.st.accum = {s.accum[30:0], b};
					r.st.left  = s.left - 6'd1;
					if (r.st.left == 6'd0) begin
						v          = ((32'd1 << s.lz[4:0]) - 32'd1) + r.st.accum;
						ready      = 1'b1;
						r.st.lz    = 6'd0;
						r.st.accum = '0;
					end
				end
				if (ready) begin
					unique case (s.field)
						F_SPS_ID: begin
							if (high_profile(s.profile)) begin
								r.st.field = F_CHROMA;
							end else begin
								r.st.chroma = 2'd1;
								r.st.field  = F_FRAME_NUM;
							end
						end
						F_CHROMA: begin
							r.st.chroma = (v > 32'd3) ? 2'd2 : v[1:0];
							r.st.field  = (v == 32'd3) ? F_RESID : F_DEPTH_L;
						end
						F_DEPTH_L:   r.st.field = F_DEPTH_C;
						F_DEPTH_C:   r.st.field = F_BYPASS;
						F_FRAME_NUM: r.st.field = F_POC_TYPE;
						F_POC_TYPE: begin
							if (v == 32'd0)
								r.st.field = F_POC_LSB;
							else if (v == 32'd1)
								r.st.field = F_DELTA_ZERO;
							else
								r.st.field = F_NUM_REF;
						end
						F_POC_LSB:    r.st.field = F_NUM_REF;
						F_OFF_NONREF: r.st.field = F_OFF_TB;
						F_OFF_TB:     r.st.field = F_NUM_CYCLE;
						F_NUM_CYCLE: begin
							r.st.rep   = v;
							r.st.field = (v == 32'd0) ? F_NUM_REF : F_OFF_REF;
						end
						F_OFF_REF: begin
							r.st.rep = s.rep - 32'd1;
							if (s.rep == 32'd1)
								r.st.field = F_NUM_REF;
						end
						F_NUM_REF: r.st.field = F_GAPS;
						F_WIDTH: begin
							r.st.wib   = sat16(v);
							r.st.field = F_HEIGHT;
						end
						F_HEIGHT: begin
							r.st.hiu   = sat16(v);
							r.st.field = F_FMO;
						end
						F_CROP0: begin
							r.st.crop0 = sat16(v);
							r.st.field = F_CROP1;
						end
						F_CROP1: begin
							r.st.crop1 = sat16(v);
							r.st.field = F_CROP2;
						end
						F_CROP2: begin
							r.st.crop2 = sat16(v);
							r.st.field = F_CROP3;
						end
						F_CROP3: begin
							r.st.crop3 = sat16(v);
							r.done     = 1'b1;
							r.fin      = 1'b1;
						end
						default: r.st.field = s.field;
					endcase
				end
			end
		endcase
		return r;
	endfunction

	parse_st_t st_q;
	parse_st_t nx;
	step_t     so;
	logic      skip;
	logic      res_done;
	logic      res_fin;
	status_t   res_status;
	logic      req_valid_s1;
	size_req_t req_s1;

	assign q_pop     = q_valid && (!req_valid_s1 || req_take);
	assign req_valid = req_valid_s1;
	assign req       = req_s1;

	always_comb begin
		nx         = st_q;
		so         = '0;
		skip       = 1'b0;
		res_done   = 1'b0;
		res_fin    = 1'b0;
		res_status = ST_OK;
		if (q_item.first) begin
			nx         = '0;
			nx.profile = q_item.data;
			nx.field   = F_CONSTR;
		end else if (st_q.sent || st_q.field == F_IDLE) begin
			skip = 1'b1;
		end else if (st_q.field == F_CONSTR) begin
			nx.field = F_LEVEL;
		end else if (st_q.field == F_LEVEL) begin
			nx.field = F_SPS_ID;
		end else begin
			for (int i = 7; i >= 0; i--) begin
				if (!res_done) begin
					so         = bit_step(nx, q_item.data[3'(i)]);
					nx         = so.st;
					res_done   = so.done;
					res_fin    = so.fin;
					res_status = so.status;
				end
			end
		end
		if (!skip && !res_done && q_item.last) begin
			res_done   = 1'b1;
			res_status = ST_TRUNC;
		end
		if (res_done) begin
			nx.sent  = 1'b1;
			nx.field = F_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_RESET;
			req_valid_s1 <= 1'b0;
		end else begin
			if (q_pop) begin
				st_q <= nx;
				if (res_done)
					req_valid_s1 <= 1'b1;
				else if (req_take)
					req_valid_s1 <= 1'b0;
			end else if (req_take) begin
				req_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && res_done) begin
			req_s1.fin    <= res_fin;
			req_s1.status <= res_status;
			req_s1.wib    <= nx.wib;
			req_s1.hiu    <= nx.hiu;
			req_s1.fo     <= nx.fo;
			req_s1.chroma <= nx.chroma;
			req_s1.crop0  <= nx.crop0;
			req_s1.crop1  <= nx.crop1;
			req_s1.crop2  <= nx.crop2;
			req_s1.crop3  <= nx.crop3;
		end
	end

endmodule

>>> src/h264sps_size.sv
// Size stage: applies cropping to the coded frame size and holds the result
// in the output register. Depends on h264sps_pkg.
module h264sps_size #(
	parameter int DIM_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  h264sps_pkg::size_req_t req,
	output logic                   req_take,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [15:0]            frame_width,
	output logic [15:0]            frame_height,
	output logic [2:0]             status
);
	import h264sps_pkg::*;

	localparam logic [15:0] LIM = (DIM_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << DIM_BITS) - 32'd1);

	logic [21:0] w;
	logic [21:0] hb;
	logic [21:0] h;
	logic [21:0] sx;
	logic [21:0] sy;
	logic [21:0] cw;
	logic [21:0] ch;
	logic [21:0] wo;
	logic [21:0] ho;
	logic [1:0]  ysh;
	logic        crop_bad;
	logic        out_valid_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  status_q;

	assign req_take     = req_valid && (!out_valid_q || !out_stall);
	assign out_valid    = out_valid_q;
	assign frame_width  = width_q;
	assign frame_height = height_q;
	assign status       = status_q;

	always_comb begin
		w   = (22'(req.wib) + 22'd1) << 4;
		hb  = (22'(req.hiu) + 22'd1) << 4;
		h   = req.fo ? hb : (hb << 1);
		sx  = 22'(req.crop0) + 22'(req.crop1);
		sy  = 22'(req.crop2) + 22'(req.crop3);
		// 4:2:0 and 4:2:2 crop in pairs of luma columns
		cw  = (req.chroma == 2'd1 || req.chroma == 2'd2) ? (sx << 1) : sx;
		ysh = {1'b0, !req.fo} + {1'b0, req.chroma == 2'd1};
		ch  = sy << ysh;
		crop_bad = (cw > w) || (ch > h);
		wo  = w - cw;
		ho  = h - ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			if (!req.fin) begin
				width_q  <= '0;
				height_q <= '0;
				status_q <= req.status;
			end else if (crop_bad) begin
				width_q  <= '0;
				height_q <= '0;
				status_q <= ST_CROP;
			end else begin
				width_q  <= (wo > 22'(LIM)) ? LIM : wo[15:0];
				height_q <= (ho > 22'(LIM)) ? LIM : ho[15:0];
				status_q <= ST_OK;
			end
		end
	end

endmodule

>>> src/h264_sps_frame_size_parser.sv
// Top level of the H.264 SPS frame size parser.
// Instantiates h264sps_queue, h264sps_parse and h264sps_size; uses h264sps_pkg.
//
// Usage: feed SPS payload bytes on the input channel (data_byte, first_byte,
// last_byte under in_valid/in_stall), starting with the profile_idc byte
// flagged by first_byte. Emulation-prevention bytes must already be removed.
// One result per SPS leaves on the output channel (frame_width, frame_height,
// status under out_valid/out_stall) once the cropping flag and any cropping offsets are read, or
// on a scaling list, an overlong code or truncation at last_byte.
// Throughput: one byte per cycle while no result waits on a stalled receiver;
// the bit parser consumes all eight bits of a byte together. The byte that
// completes a result passes the queue, parse register and output register.
// Reset: queue emptied, parser idle until a first_byte, no result pending.
// A stalled receiver holds the result; a finish request then waits in the parse
// register, and the two-entry queue fills before in_stall rises.
module h264_sps_frame_size_parser #(
	parameter int DIM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] frame_width,
	output logic [15:0] frame_height,
	output logic [2:0]  status
);
	import h264sps_pkg::*;

	byte_item_t in_item;
	byte_item_t q_item;
	logic       q_valid;
	logic       q_pop;
	logic       req_valid;
	logic       req_take;
	size_req_t  req;

	assign in_item.data  = data_byte;
	assign in_item.first = first_byte;
	assign in_item.last  = last_byte;

	h264sps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	h264sps_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take)
	);

	h264sps_size #(
		.DIM_BITS (DIM_BITS)
	) u_size (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req          (req),
		.req_take     (req_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.status       (status)
	);

endmodule
